[rtl/lzc_pkg.sv]
`default_nettype none

package lzc_pkg;

    // dictionary size and the widths that follow from it
    localparam int DICT_ENTRIES = 4096;
    localparam int IDX_W        = $clog2(DICT_ENTRIES + 1);
    localparam int ENT_W        = $clog2(DICT_ENTRIES);
    localparam int SLOT_W       = ENT_W + 1;
    localparam int TBL_DEPTH    = 1 << SLOT_W;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int PREFIX_W = 13;
    localparam int CAP_W    = 24;
    localparam int KEY_W    = BYTE_W + IDX_W;

    // stream and register port widths
    localparam int OUT_FIELDS_W = PREFIX_W + BYTE_W + CAP_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 2;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // register map (word index taken from paddr above the byte offset)
    localparam logic REG_CAPACITY = 1'b0;

    // output byte accounting
    localparam logic [CAP_W-1:0] CAP_RESET         = 24'hFF_FFFF;
    localparam logic [CAP_W-1:0] FLAG_BYTES        = 24'd1;
    localparam logic [CAP_W:0]   PAIR_TOKEN_BYTES  = 25'd3;
    localparam logic [CAP_W:0]   INDEX_TOKEN_BYTES = 25'd2;

    // one dictionary entry: owning hash slot, prefix index and byte
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  prefix;
        logic [BYTE_W-1:0] ch;
    } dict_entry_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic start;
        logic drop;
        logic miss;
        logic hit;
        logic probe_step;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic failed;
        logic tbl_live;
        logic dict_live;
        logic key_match;
        logic out_busy;
    } status_t;

    // fold the (match, byte) key onto a hash slot
    function automatic logic [SLOT_W-1:0] hash_slot(input logic [IDX_W-1:0] match,
                                                    input logic [BYTE_W-1:0] ch);
        logic [KEY_W-1:0] key;
        key = {ch, match};
        return key[SLOT_W-1:0] ^ SLOT_W'(key >> SLOT_W);
    endfunction

endpackage

`default_nettype wire

[rtl/lz78_dictionary_compressor.sv]
`default_nettype none

// LZ78 compressor taking one byte a word and giving (prefix, byte) tokens, or
// an index-only token when a block ends on a match. Each byte is looked up in
// a 2*DICT_ENTRIES-slot hash table with linear probing, checked against the
// dictionary entry it points at; a mismatch moves on to the next slot, and the
// token waits while the result register is stalled. A new byte is taken only
// once the last one is committed. The table is at most half full, so probe
// chains stay short. After reset the table is swept clear, one slot a cycle,
// with s_tready low; configuration writes are taken meanwhile. A result closing
// the block (tlast) carries the total compressed size including the leading
// flag byte, but an overflow result closes the block with a zero total and the
// rest of that block's bytes are dropped. output_capacity lives at byte address
// 0 and should be written only while the block is idle.
module lz78_dictionary_compressor (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input words
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // byte_value
    input  wire logic                                s_tlast,
    // result words
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // prefix_index[12:0], token_byte[20:13], total_bytes[44:21], zero pad
    output logic [lzc_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // has_character[0], overflow[1]
    output logic [lzc_pkg::OUT_TUSER_W-1:0]          m_tuser,
    output logic                                     m_tlast,
    // register port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lzc_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [lzc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lzc_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                     pready
);

    lzc_pkg::cmd_t    cmd;
    lzc_pkg::status_t st;

    logic [lzc_pkg::CAP_W-1:0]    cap_reg;
    logic                         reg_sel;
    logic                         cfg_wr;
    logic [lzc_pkg::PREFIX_W-1:0] res_prefix;
    logic [lzc_pkg::BYTE_W-1:0]   res_byte;
    logic                         res_has_char;
    logic                         res_overflow;
    logic [lzc_pkg::CAP_W-1:0]    res_total;

    // register decode
    assign pready  = 1'b1;
    assign reg_sel = (paddr[lzc_pkg::APB_ADDR_W-1:2] == lzc_pkg::REG_CAPACITY);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? lzc_pkg::APB_DATA_W'(cap_reg) : '0;

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lzc_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            cap_reg <= pwdata[lzc_pkg::CAP_W-1:0];
        end
    end

    lzc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lzc_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .st         (st),
        .s_byte     (s_tdata),
        .s_last     (s_tlast),
        .capacity   (cap_reg),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_prefix   (res_prefix),
        .m_byte     (res_byte),
        .m_has_char (res_has_char),
        .m_overflow (res_overflow),
        .m_last     (m_tlast),
        .m_total    (res_total)
    );

    // result packing
    assign m_tdata = lzc_pkg::OUT_TDATA_W'({res_total, res_byte, res_prefix});
    assign m_tuser = {res_overflow, res_has_char};

endmodule

`default_nettype wire

[rtl/lzc_ctrl.sv]
`default_nettype none

module lzc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire lzc_pkg::status_t st,
    output lzc_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        TWAIT,
        TCHK,
        DCHK,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            CLEAR: begin
                cmd.clear = 1'b1;
                if (st.clear_done) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (st.failed) begin
                        cmd.drop = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = TWAIT;
                    end
                end
            end
            TWAIT: begin
                state_next = TCHK;
            end
            TCHK: begin
                if (st.tbl_live) begin
                    state_next = DCHK;
                end else begin
                    cmd.miss   = 1'b1;
                    state_next = FINISH;
                end
            end
            DCHK: begin
                priority if (st.dict_live && st.key_match) begin
                    cmd.hit    = 1'b1;
                    state_next = FINISH;
                end else if (st.dict_live) begin
                    cmd.probe_step = 1'b1;
                    state_next     = TWAIT;
                end else begin
                    cmd.miss   = 1'b1;
                    state_next = FINISH;
                end
            end
            FINISH: begin
                if (!st.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lzc_datapath.sv]
`default_nettype none

module lzc_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire lzc_pkg::cmd_t                  cmd,
    output lzc_pkg::status_t                    st,
    input  wire logic [lzc_pkg::BYTE_W-1:0]     s_byte,
    input  wire logic                           s_last,
    input  wire logic [lzc_pkg::CAP_W-1:0]      capacity,
    input  wire logic                           m_tready,
    output logic                                m_tvalid,
    output logic [lzc_pkg::PREFIX_W-1:0]        m_prefix,
    output logic [lzc_pkg::BYTE_W-1:0]          m_byte,
    output logic                                m_has_char,
    output logic                                m_overflow,
    output logic                                m_last,
    output logic [lzc_pkg::CAP_W-1:0]           m_total
);

    // memories: hash table of entry numbers and the dictionary itself
    logic [lzc_pkg::ENT_W-1:0] tbl_mem [lzc_pkg::TBL_DEPTH];
    lzc_pkg::dict_entry_t      dict_mem [lzc_pkg::DICT_ENTRIES];
    logic [lzc_pkg::ENT_W-1:0] tbl_q;
    lzc_pkg::dict_entry_t      dict_q;
    lzc_pkg::dict_entry_t      dict_wr;

    // block state
    logic [lzc_pkg::IDX_W-1:0]  count_reg, count_next;
    logic [lzc_pkg::IDX_W-1:0]  match_reg, match_next;
    logic [lzc_pkg::CAP_W-1:0]  bytes_reg, bytes_next;
    logic                       failed_reg, failed_next;

    // per word working registers
    logic [lzc_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       last_reg, last_next;
    logic [lzc_pkg::SLOT_W-1:0] probe_reg, probe_next;
    logic                       hit_reg, hit_next;
    logic [lzc_pkg::IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [lzc_pkg::SLOT_W-1:0] clr_reg, clr_next;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic [lzc_pkg::PREFIX_W-1:0] out_prefix_reg, out_prefix_next;
    logic [lzc_pkg::BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                         out_has_reg, out_has_next;
    logic                         out_ovf_reg, out_ovf_next;
    logic                         out_last_reg, out_last_next;
    logic [lzc_pkg::CAP_W-1:0]    out_total_reg, out_total_next;

    logic [lzc_pkg::CAP_W:0] sum;
    logic                    fits;
    logic                    room;
    logic                    insert_en;

    // status towards the controller
    always_comb begin
        st.clear_done = (clr_reg == lzc_pkg::SLOT_W'(lzc_pkg::TBL_DEPTH - 1));
        st.failed     = failed_reg;
        st.tbl_live   = (lzc_pkg::IDX_W'(tbl_q) < count_reg);
        st.dict_live  = (dict_q.slot == probe_reg);
        st.key_match  = (dict_q.prefix == match_reg) && (dict_q.ch == byte_reg);
        st.out_busy   = out_valid_reg && !m_tready;
    end

    // byte budget for the token in hand
    always_comb begin
        sum  = {1'b0, bytes_reg} + (hit_reg ? lzc_pkg::INDEX_TOKEN_BYTES
                                            : lzc_pkg::PAIR_TOKEN_BYTES);
        fits = (sum <= {1'b0, capacity});
        room = (count_reg < lzc_pkg::IDX_W'(lzc_pkg::DICT_ENTRIES));
    end

    // next state of block, working and result registers
    always_comb begin
        count_next      = count_reg;
        match_next      = match_reg;
        bytes_next      = bytes_reg;
        failed_next     = failed_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        probe_next      = probe_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_prefix_next = out_prefix_reg;
        out_byte_next   = out_byte_reg;
        out_has_next    = out_has_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        out_total_next  = out_total_reg;
        insert_en       = 1'b0;

        // table clearing sweep
        if (cmd.clear) begin
            clr_next = clr_reg + 1'b1;
        end

        // new word: latch it and aim at its home slot
        if (cmd.start) begin
            byte_next  = s_byte;
            last_next  = s_last;
            probe_next = lzc_pkg::hash_slot(match_reg, s_byte);
        end

        // word of a failed block: only its last word matters
        if (cmd.drop && s_last) begin
            count_next  = '0;
            match_next  = '0;
            bytes_next  = lzc_pkg::FLAG_BYTES;
            failed_next = 1'b0;
        end

        // probe outcome
        if (cmd.miss) begin
            hit_next = 1'b0;
        end
        if (cmd.hit) begin
            hit_next     = 1'b1;
            hit_idx_next = lzc_pkg::IDX_W'(tbl_q) + 1'b1;
        end
        if (cmd.probe_step) begin
            probe_next = probe_reg + 1'b1;
        end

        // token, dictionary update and result
        if (cmd.commit) begin
            priority if (hit_reg && !last_reg) begin
                match_next = hit_idx_reg;
            end else if (!fits) begin
                out_valid_next  = 1'b1;
                out_prefix_next = '0;
                out_byte_next   = '0;
                out_has_next    = 1'b0;
                out_ovf_next    = 1'b1;
                out_last_next   = 1'b1;
                out_total_next  = '0;
                if (last_reg) begin
                    count_next  = '0;
                    match_next  = '0;
                    bytes_next  = lzc_pkg::FLAG_BYTES;
                    failed_next = 1'b0;
                end else begin
                    failed_next = 1'b1;
                end
            end else if (hit_reg) begin
                out_valid_next  = 1'b1;
                out_prefix_next = lzc_pkg::PREFIX_W'(hit_idx_reg);
                out_byte_next   = '0;
                out_has_next    = 1'b0;
                out_ovf_next    = 1'b0;
                out_last_next   = 1'b1;
                out_total_next  = sum[lzc_pkg::CAP_W-1:0];
                count_next      = '0;
                match_next      = '0;
                bytes_next      = lzc_pkg::FLAG_BYTES;
            end else begin
                out_valid_next  = 1'b1;
                out_prefix_next = lzc_pkg::PREFIX_W'(match_reg);
                out_byte_next   = byte_reg;
                out_has_next    = 1'b1;
                out_ovf_next    = 1'b0;
                out_last_next   = last_reg;
                out_total_next  = last_reg ? sum[lzc_pkg::CAP_W-1:0] : '0;
                insert_en       = room;
                match_next      = '0;
                if (last_reg) begin
                    count_next = '0;
                    bytes_next = lzc_pkg::FLAG_BYTES;
                end else begin
                    bytes_next = sum[lzc_pkg::CAP_W-1:0];
                    if (room) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            match_reg     <= '0;
            bytes_reg     <= lzc_pkg::FLAG_BYTES;
            failed_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            match_reg     <= match_next;
            bytes_reg     <= bytes_next;
            failed_reg    <= failed_next;
            hit_reg       <= hit_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        probe_reg      <= probe_next;
        hit_idx_reg    <= hit_idx_next;
        out_prefix_reg <= out_prefix_next;
        out_byte_reg   <= out_byte_next;
        out_has_reg    <= out_has_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
        out_total_reg  <= out_total_next;
    end

    // hash table: cleared after reset, one slot a cycle
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            tbl_mem[clr_reg] <= '0;
        end else if (insert_en) begin
            tbl_mem[probe_reg] <= count_reg[lzc_pkg::ENT_W-1:0];
        end
        tbl_q <= tbl_mem[probe_reg];
    end

    // dictionary: the new entry remembers the slot that points at it
    assign dict_wr = '{slot: probe_reg, prefix: match_reg, ch: byte_reg};

    always_ff @(posedge aclk) begin
        if (insert_en) begin
            dict_mem[count_reg[lzc_pkg::ENT_W-1:0]] <= dict_wr;
        end
        dict_q <= dict_mem[tbl_q];
    end

    assign m_tvalid   = out_valid_reg;
    assign m_prefix   = out_prefix_reg;
    assign m_byte     = out_byte_reg;
    assign m_has_char = out_has_reg;
    assign m_overflow = out_ovf_reg;
    assign m_last     = out_last_reg;
    assign m_total    = out_total_reg;

    // dictionary never grows past its size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= lzc_pkg::IDX_W'(lzc_pkg::DICT_ENTRIES))
        else $error("entry count beyond dictionary size");

    // the current match always names an existing entry
    a_match_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        match_reg <= count_reg)
        else $error("match index beyond entry count");

    // an overflow result closes the block and carries no byte
    a_ovf_form: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_ovf_reg |-> out_last_reg && !out_has_reg)
        else $error("malformed overflow result");

    // a commit never overwrites a result that is still waiting
    a_no_clobber: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(out_valid_reg && !m_tready))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[test/lz78_dictionary_compressor_tb.sv]
`default_nettype none

module lz78_dictionary_compressor_tb;

    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          PAD_LSB       = lzc_pkg::PREFIX_W + lzc_pkg::BYTE_W + lzc_pkg::CAP_W;
    localparam logic [lzc_pkg::APB_ADDR_W-1:0] CAPACITY_ADDR = {lzc_pkg::REG_CAPACITY, 2'b00};

    // one byte of a block to compress
    typedef struct packed {
        logic [lzc_pkg::BYTE_W-1:0] value;
        logic                       last;
    } in_byte_t;

    // one token leaving the compressor
    typedef struct packed {
        logic [lzc_pkg::PREFIX_W-1:0] prefix_index;
        logic [lzc_pkg::BYTE_W-1:0]   token_byte;
        logic                         has_character;
        logic                         overflow;
        logic                         last;
        logic [lzc_pkg::CAP_W-1:0]    total_bytes;
    } lz_token_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [7:0]                          s_tdata  = '0;
    logic                                s_tlast  = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [lzc_pkg::OUT_TDATA_W-1:0]     m_tdata;
    logic [lzc_pkg::OUT_TUSER_W-1:0]     m_tuser;
    logic                                m_tlast;
    logic                                psel     = 1'b0;
    logic                                penable  = 1'b0;
    logic                                pwrite   = 1'b0;
    logic [lzc_pkg::APB_ADDR_W-1:0]      paddr    = '0;
    logic [lzc_pkg::APB_DATA_W-1:0]      pwdata   = '0;
    logic [lzc_pkg::APB_DATA_W-1:0]      prdata;
    logic                                pready;

    // stimulus and scoreboard
    in_byte_t    pending_bytes[$];
    lz_token_t   expected_tokens[$];
    int unsigned bytes_queued   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned errors         = 0;
    int unsigned cycle_count    = 0;
    bit          byte_taken     = 1'b0;
    bit          send_idle      = 1'b1;
    bit          recv_stall     = 1'b1;
    int unsigned gap_left       = 0;
    int unsigned stall_left     = 0;

    // compressor mirror: dictionary keyed by (match, byte), holding 1-based index
    int unsigned dict_index [bit [lzc_pkg::PREFIX_W+lzc_pkg::BYTE_W-1:0]];
    int unsigned entry_count  = 0;
    int unsigned match_index  = 0;
    int unsigned bytes_used   = 1;
    bit          block_failed = 1'b0;
    int unsigned out_capacity = 32'h00FF_FFFF;

    lz78_dictionary_compressor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // byte_value
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // prefix_index, token_byte, total_bytes, zero pad
        .m_tuser  (m_tuser),   // has_character, overflow
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mostly no pause, sometimes a short one, now and then a long one
    function automatic int unsigned pick_pause(input bit enabled);
        int unsigned r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void report_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // every block starts with an empty dictionary and only the flag byte counted
    function automatic void restart_block();
        dict_index.delete();
        entry_count  = 0;
        match_index  = 0;
        bytes_used   = 1;
        block_failed = 1'b0;
    endfunction

    // advance the mirror by one byte; returns 1 when a token comes out
    function automatic bit compress_byte(input logic [7:0] ch, input logic last_in,
                                         output lz_token_t tok);
        bit [lzc_pkg::PREFIX_W+lzc_pkg::BYTE_W-1:0] key;
        int unsigned cost;
        tok = '0;
        // rest of an aborted block is swallowed
        if (block_failed) begin
            if (last_in)
                restart_block();
            return 1'b0;
        end
        key = {match_index[lzc_pkg::PREFIX_W-1:0], ch};
        if (dict_index.exists(key)) begin
            match_index = dict_index[key];
            if (!last_in)
                return 1'b0;
            cost = 2;
        end else begin
            cost = 3;
        end
        // token would not fit the output buffer
        if (bytes_used + cost > out_capacity) begin
            tok.overflow = 1'b1;
            tok.last     = 1'b1;
            if (last_in)
                restart_block();
            else
                block_failed = 1'b1;
            return 1'b1;
        end
        bytes_used += cost;
        tok.prefix_index = lzc_pkg::PREFIX_W'(match_index);
        // pair token: learn the new phrase while there is room
        if (cost == 3) begin
            tok.token_byte    = ch;
            tok.has_character = 1'b1;
            if (entry_count < lzc_pkg::DICT_ENTRIES) begin
                entry_count++;
                dict_index[key] = entry_count;
            end
            match_index = 0;
        end
        if (last_in) begin
            tok.last        = 1'b1;
            tok.total_bytes = lzc_pkg::CAP_W'(bytes_used);
            restart_block();
        end
        return 1'b1;
    endfunction

    task automatic add_byte(input logic [7:0] value, input logic last);
        pending_bytes.push_back('{value: value, last: last});
        bytes_queued++;
    endtask

    // block of random bytes drawn from a window of the given spread
    task automatic queue_block(input int len, input int spread);
        logic [7:0] base;
        logic [7:0] v;
        base = 8'($urandom);
        for (int i = 0; i < len; i++) begin
            if (spread >= 256)
                v = 8'($urandom);
            else
                v = base + 8'($urandom_range(0, spread - 1));
            add_byte(v, i == len - 1);
        end
    endtask

    // register access: setup then access, done when pready is seen
    task automatic apb_transfer(input bit is_write, input logic [31:0] wdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (is_write)
            out_capacity = 32'(wdata[lzc_pkg::CAP_W-1:0]);
        else
            report_field("output_capacity", out_capacity, 32'(prdata[lzc_pkg::CAP_W-1:0]));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait for all words to go in and all tokens to come out, then let the lookup finish
    task automatic drain_and_settle();
        while (bytes_accepted != bytes_queued || expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // input driver: next word from the queue after a random gap
    always @(negedge aclk) begin : feed_bytes
        in_byte_t word;
        if (aresetn && (!s_tvalid || byte_taken)) begin
            byte_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                word = pending_bytes.pop_front();
                s_tdata  <= word.value;
                s_tlast  <= word.last;
                s_tvalid <= 1'b1;
                gap_left = pick_pause(send_idle);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_pause(recv_stall);
        end
    end

    // monitor: check tokens against the mirror, feed accepted bytes into it
    always @(posedge aclk) begin : watch_ports
        lz_token_t tok;
        lz_token_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token word arrived with none expected");
                    errors++;
                end else begin
                    want = expected_tokens.pop_front();
                    report_field("prefix_index", 32'(want.prefix_index),
                                 32'(m_tdata[12:0]));
                    report_field("token_byte", 32'(want.token_byte), 32'(m_tdata[20:13]));
                    report_field("total_bytes", 32'(want.total_bytes),
                                 32'(m_tdata[44:21]));
                    report_field("tdata padding", 0,
                                 32'(m_tdata[lzc_pkg::OUT_TDATA_W-1:PAD_LSB]));
                    report_field("has_character", 32'(want.has_character),
                                 32'(m_tuser[0]));
                    report_field("overflow", 32'(want.overflow), 32'(m_tuser[1]));
                    report_field("last", 32'(want.last), 32'(m_tlast));
                end
            end
            if (s_tvalid && s_tready) begin
                bytes_accepted++;
                byte_taken = 1'b1;
                if (compress_byte(s_tdata, s_tlast, tok))
                    expected_tokens.push_back(tok);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // test sequence
    initial begin
        int          phase_items;
        int          len;
        int          spread;
        int unsigned r;
        logic [31:0] wdata;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset value, then largest capacity with junk in the upper bits
        apb_transfer(1'b0, '0);
        wdata = $urandom;
        wdata[23:0] = 24'hFF_FFFF;
        apb_transfer(1'b1, wdata);
        apb_transfer(1'b0, '0);

        // single-byte blocks at both byte extremes
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        // repeated byte: match found at the last byte gives an index-only token
        repeat (3) add_byte(8'hA5, 1'b0);
        add_byte(8'hA5, 1'b1);
        // pair token on the last byte
        add_byte(8'h55, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'hAA, 1'b1);
        drain_and_settle();

        // zero capacity: overflow mid-block then dropped bytes, and at the last byte
        apb_transfer(1'b1, 32'h0000_0000);
        add_byte(8'h12, 1'b0);
        add_byte(8'h34, 1'b0);
        add_byte(8'h56, 1'b1);
        add_byte(8'h77, 1'b1);
        drain_and_settle();

        // tight capacity: pair and index-only tokens fitting, then not
        apb_transfer(1'b1, 32'hC300_0007);
        apb_transfer(1'b0, '0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h03, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h01, 1'b1);
        repeat (3) add_byte(8'h09, 1'b0);
        add_byte(8'h09, 1'b1);
        drain_and_settle();

        // random phases over a spread of capacities
        for (int p = 0; p < 10; p++) begin
            r = $urandom_range(0, 99);
            wdata = $urandom;
            if (p == 0)
                wdata[23:0] = 24'd1;
            else if (p == 1)
                wdata[23:0] = 24'hFF_FFFF;
            else if (r < 40)
                wdata[23:0] = 24'($urandom_range(2, 60));
            else if (r < 70)
                wdata[23:0] = 24'($urandom_range(61, 400));
            apb_transfer(1'b1, wdata);
            apb_transfer(1'b0, '0);
            send_idle  = (p % 4 != 3);
            recv_stall = (p % 3 != 2);
            phase_items = 0;
            while (phase_items < 80) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    // repetitive text, long matches
                    len    = $urandom_range(2, 40);
                    spread = $urandom_range(1, 4);
                end else if (r < 85) begin
                    // short noise blocks over the full byte range
                    len    = $urandom_range(1, 6);
                    spread = 256;
                end else begin
                    len    = $urandom_range(40, 120);
                    spread = $urandom_range(2, 16);
                end
                queue_block(len, spread);
                phase_items += len;
            end
            drain_and_settle();
        end

        // one longer block at full capacity, words back to back
        wdata = $urandom;
        wdata[23:0] = 24'hFF_FFFF;
        apb_transfer(1'b1, wdata);
        send_idle  = 1'b0;
        recv_stall = 1'b0;
        for (int i = 0; i < 64; i++)
            add_byte(8'(i), 1'b0);
        for (int i = 0; i < 40; i++) begin
            add_byte(8'($urandom), 1'b0);
            add_byte(8'($urandom), i == 39);
        end
        drain_and_settle();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
